// ===== sv/vsp_pkg.sv =====
// ----------------------------------------------------------------------------
// vsp_pkg
// Shared codes, widths and controller/datapath interface types for the
// variant selection policy block.
// ----------------------------------------------------------------------------
package vsp_pkg;

  // Selection modes (codes 6 and 7 fall back to the first variant)
  localparam logic [2:0] MODE_FIRST       = 3'd0;
  localparam logic [2:0] MODE_RANDOM      = 3'd1;
  localparam logic [2:0] MODE_NO_REPEAT   = 3'd2;
  localparam logic [2:0] MODE_WEIGHTED    = 3'd3;
  localparam logic [2:0] MODE_SHUFFLE     = 3'd4;
  localparam logic [2:0] MODE_ROUND_ROBIN = 3'd5;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SELECT_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_VARIANT_TOTAL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS_LOW   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS_HIGH  = 2'd3;

  // Fixed field and datapath widths
  localparam int RAND_W     = 16;
  localparam int SLOT_W     = 8;
  localparam int LANES      = 16;
  localparam int DIV_W      = 12;  // holds 16 weights of 8 bits summed
  localparam logic [LANES-1:0] ALL_BITS = 16'hFFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic prep;
    logic sum_step;
    logic div_set;
    logic div_step;
    logic scan_step;
    logic emit;
  } vsp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] mode;
    logic       cnt_last;
    logic       div_last;
    logic       scan_hit;
    logic       div_zero;
  } vsp_status_t;

endpackage

// ===== sv/vsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// vsp_ctrl
// Sequencer for one request: prepare, sum, divide, scan, then hand the
// result beat to the output register.
// ----------------------------------------------------------------------------
module vsp_ctrl import vsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  vsp_status_t sts,
  output vsp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SUM,
    S_DIVSET,
    S_DIV,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   scan_mode;
  logic   div_mode;

  assign scan_mode = (sts.mode inside {MODE_WEIGHTED, MODE_SHUFFLE});
  assign div_mode  = (sts.mode inside {MODE_RANDOM, MODE_NO_REPEAT});
  assign in_stall  = (state != S_IDLE);

  // Sequence the phases and issue one command set per cycle
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (scan_mode) begin
          state_next = S_SUM;
        end else if (div_mode) begin
          state_next = S_DIVSET;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.cnt_last) begin
          state_next = S_DIVSET;
        end
      end
      S_DIVSET: begin
        cmd.div_set = 1'b1;
        state_next  = sts.div_zero ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = scan_mode ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.cnt_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold the output beat until taken, load it on emit
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/vsp_dpath.sv =====
// ----------------------------------------------------------------------------
// vsp_dpath
// Configuration registers, selection state, serial weight/candidate
// accumulator, bit-serial restoring divider and serial scan unit.
// ----------------------------------------------------------------------------
module vsp_dpath import vsp_pkg::*; #(
  parameter int MAX_VARIANTS = 16,
  parameter int WEIGHT_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic [RAND_W-1:0]      random_value,
  input  logic [4:0]             previous_choice,
  output logic [3:0]             chosen_index,
  output logic                   weight_error,
  input  vsp_cmd_t               cmd,
  output vsp_status_t            sts
);

  localparam logic [SLOT_W-1:0] WMASK =
    (WEIGHT_BITS >= SLOT_W) ? {SLOT_W{1'b1}} : SLOT_W'((1 << WEIGHT_BITS) - 1);
  localparam logic [4:0] MAX_N = 5'(MAX_VARIANTS);

  // Configuration and persistent state
  logic [2:0]       select_mode;
  logic [4:0]       variant_total;
  logic [63:0]      weights_low;
  logic [63:0]      weights_high;
  logic [4:0]       rotation_pointer;
  logic [LANES-1:0] bag_remaining;

  // Per-request working registers
  logic [RAND_W-1:0] rand_lat;
  logic [4:0]        prev_lat;
  logic [LANES-1:0]  cand;
  logic [DIV_W-1:0]  acc;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  rem;
  logic [RAND_W-1:0] dividend;
  logic [3:0]        div_cnt;
  logic [3:0]        cnt;
  logic [3:0]        res_idx;
  logic              res_err;

  // Combinational helpers
  logic [4:0]        n_act;
  logic [127:0]      weights_all;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] term;
  logic              adj;
  logic [DIV_W-1:0]  div_sel;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  rem_next;
  logic [3:0]        rnd_idx;
  logic [LANES-1:0]  lane_mask;
  logic [LANES-1:0]  bag_masked;
  logic              refill;
  logic [LANES-1:0]  bag_new;
  logic              excl;
  logic [LANES-1:0]  cand_new;
  logic [3:0]        rr_idx;

  // Clamp the variant count to 1..MAX_VARIANTS
  always_comb begin
    if (variant_total == 5'd0) begin
      n_act = 5'd1;
    end else if (variant_total > MAX_N) begin
      n_act = MAX_N;
    end else begin
      n_act = variant_total;
    end
  end

  // Select the term of the current variant: weight or candidate bit
  assign weights_all = {weights_high, weights_low};
  assign slot        = weights_all[{cnt, 3'b000} +: SLOT_W];
  assign term        = (select_mode == MODE_SHUFFLE) ? {{(SLOT_W-1){1'b0}}, cand[cnt]}
                                                     : (slot & WMASK);

  // Pick the divisor for this request
  assign adj = (n_act >= 5'd2) && (prev_lat < n_act);
  always_comb begin
    case (select_mode)
      MODE_RANDOM:    div_sel = DIV_W'(n_act);
      MODE_NO_REPEAT: div_sel = adj ? DIV_W'(n_act - 5'd1) : DIV_W'(n_act);
      default:        div_sel = acc;
    endcase
  end

  // One restoring division step per cycle
  assign trial    = {rem, dividend[RAND_W-1]};
  assign rem_next = (trial >= {1'b0, divisor}) ? DIV_W'(trial - {1'b0, divisor})
                                               : trial[DIV_W-1:0];

  // Skip past the previous choice in no-repeat mode
  always_comb begin
    rnd_idx = rem_next[3:0];
    if ((select_mode == MODE_NO_REPEAT) && adj && (rem_next >= DIV_W'(prev_lat))) begin
      rnd_idx = rem_next[3:0] + 4'd1;
    end
  end

  // Refill the bag when empty and drop the previous choice right after refill
  assign lane_mask  = ~(ALL_BITS << n_act);
  assign bag_masked = bag_remaining & lane_mask;
  assign refill     = (bag_masked == '0);
  assign bag_new    = refill ? lane_mask : bag_masked;
  assign excl       = refill && (n_act > 5'd1) && (prev_lat < n_act);
  assign cand_new   = excl ? (bag_new & ~(LANES'(1) << prev_lat[3:0])) : bag_new;

  // Round-robin pick
  assign rr_idx = (rotation_pointer < n_act) ? rotation_pointer[3:0] : 4'd0;

  // Status for the controller
  assign sts.mode     = select_mode;
  assign sts.cnt_last = ({1'b0, cnt} == (n_act - 5'd1));
  assign sts.div_last = (div_cnt == 4'hF);
  assign sts.scan_hit = (rem < DIV_W'(term));
  assign sts.div_zero = (div_sel == '0);

  // Configuration and persistent selection state
  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode      <= MODE_FIRST;
      variant_total    <= 5'd1;
      weights_low      <= '0;
      weights_high     <= '0;
      rotation_pointer <= '0;
      bag_remaining    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SELECT_MODE:   select_mode   <= cfg_data[2:0];
          REG_VARIANT_TOTAL: variant_total <= cfg_data[4:0];
          REG_WEIGHTS_LOW:   weights_low   <= cfg_data;
          REG_WEIGHTS_HIGH:  weights_high  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.prep && (select_mode == MODE_SHUFFLE)) begin
        bag_remaining <= bag_new;
      end
      if (cmd.prep && (select_mode == MODE_ROUND_ROBIN)) begin
        rotation_pointer <= {1'b0, rr_idx} + 5'd1;
      end
      if (cmd.scan_step && sts.scan_hit && (select_mode == MODE_SHUFFLE)) begin
        bag_remaining[cnt] <= 1'b0;
      end
    end
  end

  // Working registers and output beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rand_lat <= random_value;
      prev_lat <= previous_choice;
    end
    if (cmd.prep) begin
      acc     <= '0;
      cnt     <= '0;
      res_err <= 1'b0;
      res_idx <= (select_mode == MODE_ROUND_ROBIN) ? rr_idx : 4'd0;
      cand    <= cand_new;
    end
    if (cmd.sum_step) begin
      acc <= acc + DIV_W'(term);
      cnt <= cnt + 4'd1;
    end
    if (cmd.div_set) begin
      divisor  <= div_sel;
      rem      <= '0;
      dividend <= rand_lat;
      div_cnt  <= '0;
      cnt      <= '0;
      res_err  <= sts.div_zero && (select_mode == MODE_WEIGHTED);
    end
    if (cmd.div_step) begin
      rem      <= rem_next;
      dividend <= dividend << 1;
      div_cnt  <= div_cnt + 4'd1;
      if (sts.div_last && (select_mode inside {MODE_RANDOM, MODE_NO_REPEAT})) begin
        res_idx <= rnd_idx;
      end
    end
    if (cmd.scan_step) begin
      cnt <= cnt + 4'd1;
      if (sts.scan_hit) begin
        res_idx <= cnt;
      end else begin
        rem <= rem - DIV_W'(term);
      end
    end
    if (cmd.emit) begin
      chosen_index <= res_idx;
      weight_error <= res_err;
    end
  end

endmodule

// ===== sv/variant_selection_policy.sv =====
// ----------------------------------------------------------------------------
// variant_selection_policy
// Picks one of up to MAX_VARIANTS variants per request from a random draw,
// by first, random, no-repeat, weighted, shuffle-bag or round-robin mode.
// ----------------------------------------------------------------------------
// Sequence: first/round robin load, prepare and finish; random modes add the 16-step divider;
//   weighted/shuffle also add a serial sum and scan over n (the scan stops at the hit).
// Throughput: one request at a time; the next is taken once the result is in
//   the output register, so the serial sum, the divider, the scan and output stalls set the rate.
// Reset: synchronous; mode 0, one variant, zero weights, pointer and bag cleared.
module variant_selection_policy import vsp_pkg::*; #(
  parameter int MAX_VARIANTS = 16,
  parameter int WEIGHT_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [RAND_W-1:0]      random_value,
  input  logic [4:0]             previous_choice,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             chosen_index,
  output logic                   weight_error,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  vsp_cmd_t    cmd;
  vsp_status_t sts;

  // Take configuration beats at any time
  assign cfg_ready = 1'b1;

  vsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  vsp_dpath #(
    .MAX_VARIANTS (MAX_VARIANTS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .random_value    (random_value),
    .previous_choice (previous_choice),
    .chosen_index    (chosen_index),
    .weight_error    (weight_error),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== sv/vsp_checker.sv =====
// ----------------------------------------------------------------------------
// vsp_checker
// Port-level checks for the variant selection policy block, bound to the
// top level.
// ----------------------------------------------------------------------------
module vsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] chosen_index,
  input logic       weight_error
);

  // Block is busy the cycle after it takes a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous request still in progress");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(chosen_index)
                                  && $stable(weight_error)))
    else $error("output beat changed while stalled");

  // Zero total weight always returns the first variant
  a_error_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && weight_error) |-> (chosen_index == 4'd0))
    else $error("weight error with nonzero index");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind variant_selection_policy vsp_checker u_vsp_checker (.*);
